// ===== sv/key_autorepeat_detector_assert.svh =====
// assertion macros for the checker of the key auto-repeat detector
`ifndef KEY_AUTOREPEAT_DETECTOR_ASSERT_SVH
`define KEY_AUTOREPEAT_DETECTOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KARD_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("kard check failed");

// next-cycle implication, checked outside reset
`define KARD_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("kard check failed");

`endif

// ===== sv/kard_pkg.sv =====
package kard_pkg;

   // register and field widths
   localparam int TickCountWidth = 8;
   localparam int CsrIndexWidth  = 2;
   localparam int CsrDataWidth   = 8;
   localparam int EventWidth     = 2;

   typedef logic [TickCountWidth-1:0] tick_count_type;
   typedef logic [CsrIndexWidth-1:0]  csr_index_type;
   typedef logic [CsrDataWidth-1:0]   csr_data_type;
   typedef logic [EventWidth-1:0]     key_event_type;

   // register indexes
   localparam csr_index_type CSR_HOLD_DELAY    = 2'd0;
   localparam csr_index_type CSR_REPEAT_PERIOD = 2'd1;
   localparam csr_index_type CSR_RELEASE_MODE  = 2'd2;

   // register reset values
   localparam tick_count_type HOLD_DELAY_RESET    = 8'd10;
   localparam tick_count_type REPEAT_PERIOD_RESET = 8'd2;
   localparam logic           RELEASE_MODE_RESET  = 1'b0;

   // event codes
   localparam key_event_type EVENT_IDLE   = 2'd0;
   localparam key_event_type EVENT_CLICK  = 2'd1;
   localparam key_event_type EVENT_REPEAT = 2'd2;
   localparam key_event_type EVENT_HELD   = 2'd3;

   localparam tick_count_type TICK_COUNT_MAX = '1;

endpackage

// ===== sv/key_autorepeat_detector.sv =====
// key auto-repeat detector
// a result is registered and shown in the cycle after its input transfer
// throughput: one item per cycle while the input side is not stalled; the key state and tick counter update in one pass
// the input side stalls only while the result register is full and stalled
// synchronous active-high reset clears the key state, counter and result valid,
// and loads hold delay 10, repeat period 2 and press mode
module key_autorepeat_detector (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_key_level,
   input  logic                   req_tick,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output kard_pkg::key_event_type rsp_key_event,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  kard_pkg::csr_index_type csr_index,
   input  kard_pkg::csr_data_type  csr_data
);
   import kard_pkg::*;

   // configuration registers
   tick_count_type hold_delay_ff, hold_delay_in;
   tick_count_type repeat_period_ff, repeat_period_in;
   logic           release_mode_ff, release_mode_in;

   // key state
   logic           last_level_ff, last_level_in;
   logic           repeating_ff, repeating_in;
   logic           long_hold_ff, long_hold_in;
   tick_count_type elapsed_ff, elapsed_in;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   key_event_type  key_event_ff, key_event_in;

   logic           req_accept;
   tick_count_type elapsed_tick;
   key_event_type  event_next;
   logic           hold_met;
   logic           start_rep;
   logic           rep_now;
   tick_count_type elapsed_mid;

   assign csr_ready     = 1'b1;
   assign req_stall     = rsp_valid_ff & rsp_stall;
   assign req_accept    = req_valid & ~req_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_event = key_event_ff;

   // register writes
   always_comb begin
      hold_delay_in    = hold_delay_ff;
      repeat_period_in = repeat_period_ff;
      release_mode_in  = release_mode_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HOLD_DELAY:    hold_delay_in    = csr_data;
            CSR_REPEAT_PERIOD: repeat_period_in = csr_data;
            CSR_RELEASE_MODE:  release_mode_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   // tick counter advance, saturating
   assign elapsed_tick = (req_tick && elapsed_ff != TICK_COUNT_MAX)
                         ? elapsed_ff + 1'b1 : elapsed_ff;
   assign hold_met = elapsed_tick >= hold_delay_ff;

   // next key state and event for one item
   always_comb begin
      last_level_in = last_level_ff;
      repeating_in  = repeating_ff;
      long_hold_in  = long_hold_ff;
      elapsed_in    = elapsed_tick;
      event_next    = EVENT_IDLE;
      start_rep     = 1'b0;
      rep_now       = 1'b0;
      elapsed_mid   = elapsed_tick;
      if (!release_mode_ff) begin
         // press mode: click on the press edge
         if (!last_level_ff && req_key_level) begin
            last_level_in = 1'b1;
            elapsed_in    = '0;
            event_next    = EVENT_CLICK;
         end else begin
            last_level_in = req_key_level;
            if (req_key_level) begin
               start_rep    = !repeating_ff && hold_met;
               rep_now      = repeating_ff | start_rep;
               elapsed_mid  = start_rep ? '0 : elapsed_tick;
               repeating_in = rep_now;
               elapsed_in   = elapsed_mid;
               if (rep_now && elapsed_mid >= repeat_period_ff) begin
                  elapsed_in = '0;
                  event_next = EVENT_REPEAT;
               end
            end else begin
               repeating_in = 1'b0;
            end
         end
      end else begin
         // release mode: click on release unless held long
         if (!long_hold_ff && last_level_ff && !req_key_level) begin
            last_level_in = 1'b0;
            elapsed_in    = '0;
            event_next    = EVENT_CLICK;
         end else if (last_level_ff && req_key_level) begin
            start_rep    = !repeating_ff && hold_met;
            rep_now      = repeating_ff | start_rep;
            repeating_in = rep_now;
            if (start_rep) begin
               long_hold_in = 1'b1;
            end
            if (rep_now && elapsed_tick >= repeat_period_ff) begin
               elapsed_in = '0;
               event_next = EVENT_REPEAT;
            end else begin
               event_next = rep_now ? EVENT_HELD : EVENT_IDLE;
            end
         end else begin
            // release after a long hold, idle, or press edge
            repeating_in  = 1'b0;
            last_level_in = req_key_level;
            if (long_hold_ff && last_level_ff && !req_key_level) begin
               long_hold_in = 1'b0;
            end
            if (!last_level_ff && req_key_level) begin
               elapsed_in = '0;
            end
         end
      end
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      key_event_in = key_event_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         key_event_in = event_next;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_delay_ff    <= HOLD_DELAY_RESET;
         repeat_period_ff <= REPEAT_PERIOD_RESET;
         release_mode_ff  <= RELEASE_MODE_RESET;
         last_level_ff    <= 1'b0;
         repeating_ff     <= 1'b0;
         long_hold_ff     <= 1'b0;
         elapsed_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         hold_delay_ff    <= hold_delay_in;
         repeat_period_ff <= repeat_period_in;
         release_mode_ff  <= release_mode_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (req_accept) begin
            last_level_ff <= last_level_in;
            repeating_ff  <= repeating_in;
            long_hold_ff  <= long_hold_in;
            elapsed_ff    <= elapsed_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      key_event_ff <= key_event_in;
   end

endmodule

// ===== sv/kard_checker.sv =====
`include "key_autorepeat_detector_assert.svh"

module kard_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input kard_pkg::key_event_type rsp_key_event
);
   import kard_pkg::*;

   // a stalled result stays and holds its code
   `KARD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_key_event))

   // the input side stalls only behind a stalled result
   `KARD_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)

   // every input transfer yields a result in the next cycle
   `KARD_ASSERT_NEXT(a_result_follows, req_valid && !req_stall, rsp_valid)

   // a new result only appears after an input transfer
   `KARD_ASSERT_NOW(a_no_invented, $rose(rsp_valid), $past(req_valid && !req_stall))

endmodule

bind key_autorepeat_detector kard_checker u_kard_checker (.*);
